[rtl/core/sph_pkg.sv]
// Shared types, constants and helper functions of the sphere vertex generator.
`timescale 1ns / 1ps

package sph_pkg;

  localparam int IDX_W      = 13;
  localparam int RES_W      = 7;
  localparam int RAD_W      = 31;
  localparam int COORD_W    = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_RESOLUTION = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z   = 3'd4;

  localparam logic [RES_W-1:0] MIN_RES      = 7'd2;
  localparam logic [RES_W-1:0] MAX_RES      = 7'd64;
  localparam logic [RES_W-1:0] RES_RESET    = 7'd24;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd65536;

  // divisor 2R and the last vertex index 2R(R-1)+1
  localparam int DIV_W         = RES_W + 1;
  localparam int LAST_W        = 2 * RES_W + 1;
  localparam int DIV_PER_STAGE = 4;
  localparam int IDX_STAGES    = (IDX_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  localparam int PHASE_W      = 32;
  localparam int PHASE_STAGES = PHASE_W / DIV_PER_STAGE;

  localparam int LANES    = 2;
  localparam int LANE_LAT = 0;
  localparam int LANE_LON = 1;

  localparam int CORDIC_STEPS     = 30;
  localparam int CORDIC_PER_STAGE = 3;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int CW               = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic signed [CW-1:0] TRIG_ONE    = CW'(1073741824);

  // unit factors are Q2.30
  localparam int UNIT_W    = 32;
  localparam int TRIG_FRAC = 30;
  localparam int TERM_W    = 34;
  localparam int PROD_W    = 64;
  localparam int PROD2_W   = TERM_W + UNIT_W;
  localparam int SUM_W     = TERM_W + 1;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic invalid;
    logic pole_s;
    logic pole_n;
  } ctl_t;

  function automatic logic [RES_W-1:0] res_clamp(input logic [RES_W-1:0] r);
    logic [RES_W-1:0] v;
    v = r;
    if (r < MIN_RES) v = MIN_RES;
    if (r > MAX_RES) v = MAX_RES;
    return v;
  endfunction

  // arctangent of 2^-k as a fraction of a full turn of 2^32
  function automatic logic signed [CW-1:0] atan_turn(input int k);
    logic signed [CW-1:0] a;
    case (k)
      0:  a = CW'(536870912);
      1:  a = CW'(316933406);
      2:  a = CW'(167458907);
      3:  a = CW'(85004756);
      4:  a = CW'(42667331);
      5:  a = CW'(21354465);
      6:  a = CW'(10679838);
      7:  a = CW'(5340245);
      8:  a = CW'(2670163);
      9:  a = CW'(1335087);
      10: a = CW'(667544);
      11: a = CW'(333772);
      12: a = CW'(166886);
      13: a = CW'(83443);
      14: a = CW'(41722);
      15: a = CW'(20861);
      16: a = CW'(10430);
      17: a = CW'(5215);
      18: a = CW'(2608);
      19: a = CW'(1304);
      20: a = CW'(652);
      21: a = CW'(326);
      22: a = CW'(163);
      23: a = CW'(81);
      24: a = CW'(41);
      25: a = CW'(20);
      26: a = CW'(10);
      27: a = CW'(5);
      28: a = CW'(3);
      29: a = CW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/sph_in_if.sv]
// Input channel: vertex index request.
`timescale 1ns / 1ps

interface sph_in_if;
  logic                     valid;
  logic                     ready;
  logic [sph_pkg::IDX_W-1:0] vertex_index;

  modport source (output valid, output vertex_index, input ready);
  modport sink   (input valid, input vertex_index, output ready);
endinterface

[rtl/core/sph_out_if.sv]
// Output channel: vertex coordinates and flags.
`timescale 1ns / 1ps

interface sph_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sph_pkg::COORD_W-1:0] coord_x;
  logic signed [sph_pkg::COORD_W-1:0] coord_y;
  logic signed [sph_pkg::COORD_W-1:0] coord_z;
  logic                               index_invalid;
  logic                               saturated;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output index_invalid, output saturated, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input index_invalid, input saturated, output ready);
endinterface

[rtl/core/sph_index.sv]
// Vertex index decode: pole and range checks, ring and segment by long division.
`timescale 1ns / 1ps

module sph_index (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid,
  input  logic [sph_pkg::IDX_W-1:0]   vertex_index,
  input  logic [sph_pkg::RES_W-1:0]   resolution,
  output sph_pkg::ctl_t               ctl,
  output logic [sph_pkg::RES_W-1:0]   n_lat,
  output logic [sph_pkg::RES_W-1:0]   n_lon
);

  logic                            k_valid;
  logic [sph_pkg::IDX_W-1:0]       k;
  logic [sph_pkg::RES_W-1:0]       res_c;
  logic [sph_pkg::DIV_W-1:0]       div;
  logic [2*sph_pkg::RES_W-1:0]     prod;
  logic [sph_pkg::LAST_W-1:0]      last;
  sph_pkg::ctl_t                   ctl_first;

  sph_pkg::ctl_t                   ctl_d [0:sph_pkg::IDX_STAGES];
  logic [sph_pkg::IDX_W-1:0]       m_d   [0:sph_pkg::IDX_STAGES];
  logic [sph_pkg::DIV_W-1:0]       rem_d [0:sph_pkg::IDX_STAGES];
  logic [sph_pkg::IDX_W-1:0]       quo_d [0:sph_pkg::IDX_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else if (en) begin
      k_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k <= vertex_index;
    end
  end

  always_comb begin
    res_c = sph_pkg::res_clamp(resolution);
    div   = {res_c, 1'b0};
    prod  = (2*sph_pkg::RES_W)'(res_c) * (2*sph_pkg::RES_W)'(res_c - 7'd1);
    last  = {prod, 1'b0} + sph_pkg::LAST_W'(1);
    ctl_first.valid   = k_valid;
    ctl_first.invalid = sph_pkg::LAST_W'(k) > last;
    ctl_first.pole_s  = (k == '0);
    ctl_first.pole_n  = (sph_pkg::LAST_W'(k) == last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d[0] <= '0;
    end else if (en) begin
      ctl_d[0] <= ctl_first;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_d[0]   <= k - sph_pkg::IDX_W'(1);
      rem_d[0] <= '0;
      quo_d[0] <= '0;
    end
  end

  // restoring division of m by 2R, a few quotient bits per stage
  for (genvar s = 0; s < sph_pkg::IDX_STAGES; s++) begin : g_stage
    logic [sph_pkg::DIV_W-1:0] rem_n;
    logic [sph_pkg::IDX_W-1:0] quo_n;
    logic [sph_pkg::DIV_W:0]   trial;

    always_comb begin
      int b;
      rem_n = rem_d[s];
      quo_n = quo_d[s];
      trial = '0;
      for (int t = 0; t < sph_pkg::DIV_PER_STAGE; t++) begin
        b = sph_pkg::IDX_W - 1 - s*sph_pkg::DIV_PER_STAGE - t;
        if (b >= 0) begin
          trial = {rem_n, m_d[s][b]};
          if (trial >= {1'b0, div}) begin
            trial = trial - {1'b0, div};
            quo_n = {quo_n[sph_pkg::IDX_W-2:0], 1'b1};
          end else begin
            quo_n = {quo_n[sph_pkg::IDX_W-2:0], 1'b0};
          end
          rem_n = trial[sph_pkg::DIV_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_d[s+1] <= '0;
      end else if (en) begin
        ctl_d[s+1] <= ctl_d[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_d[s+1]   <= m_d[s];
        rem_d[s+1] <= rem_n;
        quo_d[s+1] <= quo_n;
      end
    end
  end

  assign ctl   = ctl_d[sph_pkg::IDX_STAGES];
  assign n_lat = quo_d[sph_pkg::IDX_STAGES][sph_pkg::RES_W-1:0] + sph_pkg::RES_W'(1);
  assign n_lon = rem_d[sph_pkg::IDX_STAGES][sph_pkg::RES_W-1:0];

`ifndef SYNTH
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    ctl.valid |-> $onehot0({ctl.invalid, ctl.pole_s, ctl.pole_n}))
    else $error("index decode flags overlap");

  a_ring_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.valid && !ctl.invalid && !ctl.pole_s && !ctl.pole_n
      |-> n_lat != '0 && n_lat < res_c && sph_pkg::DIV_W'(n_lon) < div)
    else $error("ring or segment out of range");
`endif

endmodule

[rtl/core/sph_phase.sv]
// Step phase divider: (n * 2^32 + R) / 2R for the ring and segment lanes.
`timescale 1ns / 1ps

module sph_phase (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  sph_pkg::ctl_t               ctl_in,
  input  logic [sph_pkg::RES_W-1:0]   n_lat,
  input  logic [sph_pkg::RES_W-1:0]   n_lon,
  input  logic [sph_pkg::RES_W-1:0]   resolution,
  output sph_pkg::ctl_t               ctl,
  output logic [sph_pkg::PHASE_W-1:0] phase_lat,
  output logic [sph_pkg::PHASE_W-1:0] phase_lon
);

  logic [sph_pkg::RES_W-1:0]   res_c;
  logic [sph_pkg::DIV_W-1:0]   div;
  logic [sph_pkg::PHASE_W-1:0] low;

  sph_pkg::ctl_t               ctl_d [0:sph_pkg::PHASE_STAGES];
  logic [sph_pkg::DIV_W-1:0]   rem_d [0:sph_pkg::PHASE_STAGES][0:sph_pkg::LANES-1];
  logic [sph_pkg::PHASE_W-1:0] quo_d [0:sph_pkg::PHASE_STAGES][0:sph_pkg::LANES-1];

  assign res_c = sph_pkg::res_clamp(resolution);
  assign div   = {res_c, 1'b0};
  assign low   = sph_pkg::PHASE_W'(res_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d[0] <= '0;
    end else if (en) begin
      ctl_d[0] <= ctl_in;
    end
  end

  // n < 2R, so the integer part of the quotient is zero and n is the first remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem_d[0][sph_pkg::LANE_LAT] <= sph_pkg::DIV_W'(n_lat);
      rem_d[0][sph_pkg::LANE_LON] <= sph_pkg::DIV_W'(n_lon);
      quo_d[0][sph_pkg::LANE_LAT] <= '0;
      quo_d[0][sph_pkg::LANE_LON] <= '0;
    end
  end

  for (genvar s = 0; s < sph_pkg::PHASE_STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_d[s+1] <= '0;
      end else if (en) begin
        ctl_d[s+1] <= ctl_d[s];
      end
    end

    for (genvar l = 0; l < sph_pkg::LANES; l++) begin : g_lane
      logic [sph_pkg::DIV_W-1:0]   rem_n;
      logic [sph_pkg::PHASE_W-1:0] quo_n;
      logic [sph_pkg::DIV_W:0]     trial;

      always_comb begin
        int b;
        rem_n = rem_d[s][l];
        quo_n = quo_d[s][l];
        trial = '0;
        for (int t = 0; t < sph_pkg::DIV_PER_STAGE; t++) begin
          b = sph_pkg::PHASE_W - 1 - s*sph_pkg::DIV_PER_STAGE - t;
          trial = {rem_n, low[b]};
          if (trial >= {1'b0, div}) begin
            trial = trial - {1'b0, div};
            quo_n = {quo_n[sph_pkg::PHASE_W-2:0], 1'b1};
          end else begin
            quo_n = {quo_n[sph_pkg::PHASE_W-2:0], 1'b0};
          end
          rem_n = trial[sph_pkg::DIV_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_d[s+1][l] <= rem_n;
          quo_d[s+1][l] <= quo_n;
        end
      end
    end
  end

  assign ctl       = ctl_d[sph_pkg::PHASE_STAGES];
  assign phase_lat = quo_d[sph_pkg::PHASE_STAGES][sph_pkg::LANE_LAT];
  assign phase_lon = quo_d[sph_pkg::PHASE_STAGES][sph_pkg::LANE_LON];

endmodule

[rtl/core/sph_cordic.sv]
// Pipelined rotation CORDIC: sine and cosine of two phases, three rotations a stage.
`timescale 1ns / 1ps

module sph_cordic (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  sph_pkg::ctl_t                      ctl_in,
  input  logic [sph_pkg::PHASE_W-1:0]        phase_lat,
  input  logic [sph_pkg::PHASE_W-1:0]        phase_lon,
  output sph_pkg::ctl_t                      ctl,
  output logic signed [sph_pkg::UNIT_W-1:0]  cos_lat,
  output logic signed [sph_pkg::UNIT_W-1:0]  sin_lat,
  output logic signed [sph_pkg::UNIT_W-1:0]  cos_lon,
  output logic signed [sph_pkg::UNIT_W-1:0]  sin_lon
);

  logic [sph_pkg::PHASE_W-1:0]     ph     [0:sph_pkg::LANES-1];
  sph_pkg::ctl_t                   ctl_d  [0:sph_pkg::CORDIC_STAGES];
  logic signed [sph_pkg::CW-1:0]   x_d    [0:sph_pkg::CORDIC_STAGES][0:sph_pkg::LANES-1];
  logic signed [sph_pkg::CW-1:0]   y_d    [0:sph_pkg::CORDIC_STAGES][0:sph_pkg::LANES-1];
  logic signed [sph_pkg::CW-1:0]   z_d    [0:sph_pkg::CORDIC_STAGES][0:sph_pkg::LANES-1];
  logic                            flip_d [0:sph_pkg::CORDIC_STAGES][0:sph_pkg::LANES-1];
  sph_pkg::ctl_t                   ctl_q;
  logic signed [sph_pkg::UNIT_W-1:0] cos_q [0:sph_pkg::LANES-1];
  logic signed [sph_pkg::UNIT_W-1:0] sin_q [0:sph_pkg::LANES-1];

  assign ph[sph_pkg::LANE_LAT] = phase_lat;
  assign ph[sph_pkg::LANE_LON] = phase_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d[0] <= '0;
    end else if (en) begin
      ctl_d[0] <= ctl_in;
    end
  end

  // fold into [-1/4, +1/4] turn; a half-turn fold negates both results at the end
  for (genvar l = 0; l < sph_pkg::LANES; l++) begin : g_fold
    logic                        flip;
    logic [sph_pkg::PHASE_W-1:0] q;

    assign flip = ph[l][sph_pkg::PHASE_W-1] ^ ph[l][sph_pkg::PHASE_W-2];
    assign q    = flip ? {~ph[l][sph_pkg::PHASE_W-1], ph[l][sph_pkg::PHASE_W-2:0]} : ph[l];

    always_ff @(posedge clk) begin
      if (en) begin
        x_d[0][l]    <= sph_pkg::CORDIC_GAIN;
        y_d[0][l]    <= '0;
        z_d[0][l]    <= sph_pkg::CW'($signed(q));
        flip_d[0][l] <= flip;
      end
    end
  end

  for (genvar s = 0; s < sph_pkg::CORDIC_STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_d[s+1] <= '0;
      end else if (en) begin
        ctl_d[s+1] <= ctl_d[s];
      end
    end

    for (genvar l = 0; l < sph_pkg::LANES; l++) begin : g_lane
      logic signed [sph_pkg::CW-1:0] xv [0:sph_pkg::CORDIC_PER_STAGE];
      logic signed [sph_pkg::CW-1:0] yv [0:sph_pkg::CORDIC_PER_STAGE];
      logic signed [sph_pkg::CW-1:0] zv [0:sph_pkg::CORDIC_PER_STAGE];

      always_comb begin
        int k;
        xv[0] = x_d[s][l];
        yv[0] = y_d[s][l];
        zv[0] = z_d[s][l];
        for (int t = 0; t < sph_pkg::CORDIC_PER_STAGE; t++) begin
          k = s*sph_pkg::CORDIC_PER_STAGE + t;
          if (!zv[t][sph_pkg::CW-1]) begin
            xv[t+1] = xv[t] - (yv[t] >>> k);
            yv[t+1] = yv[t] + (xv[t] >>> k);
            zv[t+1] = zv[t] - sph_pkg::atan_turn(k);
          end else begin
            xv[t+1] = xv[t] + (yv[t] >>> k);
            yv[t+1] = yv[t] - (xv[t] >>> k);
            zv[t+1] = zv[t] + sph_pkg::atan_turn(k);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_d[s+1][l]    <= xv[sph_pkg::CORDIC_PER_STAGE];
          y_d[s+1][l]    <= yv[sph_pkg::CORDIC_PER_STAGE];
          z_d[s+1][l]    <= zv[sph_pkg::CORDIC_PER_STAGE];
          flip_d[s+1][l] <= flip_d[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else if (en) begin
      ctl_q <= ctl_d[sph_pkg::CORDIC_STAGES];
    end
  end

  // undo the fold and clamp to the unit range
  for (genvar l = 0; l < sph_pkg::LANES; l++) begin : g_out
    logic signed [sph_pkg::CW-1:0] xf;
    logic signed [sph_pkg::CW-1:0] yf;
    logic signed [sph_pkg::CW-1:0] xc;
    logic signed [sph_pkg::CW-1:0] yc;

    always_comb begin
      xf = flip_d[sph_pkg::CORDIC_STAGES][l] ? -x_d[sph_pkg::CORDIC_STAGES][l]
                                             :  x_d[sph_pkg::CORDIC_STAGES][l];
      yf = flip_d[sph_pkg::CORDIC_STAGES][l] ? -y_d[sph_pkg::CORDIC_STAGES][l]
                                             :  y_d[sph_pkg::CORDIC_STAGES][l];
      xc = xf;
      yc = yf;
      if (xf > sph_pkg::TRIG_ONE) xc = sph_pkg::TRIG_ONE;
      if (xf < -sph_pkg::TRIG_ONE) xc = -sph_pkg::TRIG_ONE;
      if (yf > sph_pkg::TRIG_ONE) yc = sph_pkg::TRIG_ONE;
      if (yf < -sph_pkg::TRIG_ONE) yc = -sph_pkg::TRIG_ONE;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cos_q[l] <= xc[sph_pkg::UNIT_W-1:0];
        sin_q[l] <= yc[sph_pkg::UNIT_W-1:0];
      end
    end
  end

  assign ctl     = ctl_q;
  assign cos_lat = cos_q[sph_pkg::LANE_LAT];
  assign sin_lat = sin_q[sph_pkg::LANE_LAT];
  assign cos_lon = cos_q[sph_pkg::LANE_LON];
  assign sin_lon = sin_q[sph_pkg::LANE_LON];

endmodule

[rtl/core/sph_scale.sv]
// Radius scaling, center offset and saturation of the vertex coordinates.
`timescale 1ns / 1ps

module sph_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  sph_pkg::ctl_t                       ctl_in,
  input  logic signed [sph_pkg::UNIT_W-1:0]   cos_lat,
  input  logic signed [sph_pkg::UNIT_W-1:0]   sin_lat,
  input  logic signed [sph_pkg::UNIT_W-1:0]   cos_lon,
  input  logic signed [sph_pkg::UNIT_W-1:0]   sin_lon,
  input  logic [sph_pkg::RAD_W-1:0]           radius,
  input  logic signed [sph_pkg::COORD_W-1:0]  center_x,
  input  logic signed [sph_pkg::COORD_W-1:0]  center_y,
  input  logic signed [sph_pkg::COORD_W-1:0]  center_z,
  output logic                                out_valid,
  output logic signed [sph_pkg::COORD_W-1:0]  coord_x,
  output logic signed [sph_pkg::COORD_W-1:0]  coord_y,
  output logic signed [sph_pkg::COORD_W-1:0]  coord_z,
  output logic                                index_invalid,
  output logic                                saturated
);

  localparam logic signed [sph_pkg::PROD_W-1:0]  HALF_P  =
    sph_pkg::PROD_W'(1 << (sph_pkg::TRIG_FRAC - 1));
  localparam logic signed [sph_pkg::PROD2_W-1:0] HALF_P2 =
    sph_pkg::PROD2_W'(1 << (sph_pkg::TRIG_FRAC - 1));
  localparam logic signed [sph_pkg::SUM_W-1:0]   SUM_MAX = sph_pkg::SUM_W'(2147483647);
  localparam logic signed [sph_pkg::SUM_W-1:0]   SUM_MIN = -SUM_MAX - sph_pkg::SUM_W'(1);

  logic signed [sph_pkg::COORD_W-1:0] r_s;
  logic signed [sph_pkg::UNIT_W-1:0]  neg_cos;

  // stage 1: radius products
  sph_pkg::ctl_t                       ctl1;
  logic signed [sph_pkg::PROD_W-1:0]   pt1, pz1;
  logic signed [sph_pkg::UNIT_W-1:0]   clon1, slon1;
  // stage 2: rounded ring radius and z term
  sph_pkg::ctl_t                       ctl2;
  logic signed [sph_pkg::TERM_W-1:0]   t2, zt2;
  logic signed [sph_pkg::UNIT_W-1:0]   clon2, slon2;
  // stage 3: longitude products
  sph_pkg::ctl_t                       ctl3;
  logic signed [sph_pkg::PROD2_W-1:0]  px3, py3;
  logic signed [sph_pkg::TERM_W-1:0]   zt3;
  // stage 4: final terms
  sph_pkg::ctl_t                       ctl4;
  logic signed [sph_pkg::TERM_W-1:0]   xt4, yt4, zt4;
  logic signed [sph_pkg::TERM_W-1:0]   xt_n, yt_n, zt_n;
  // stage 5: sums
  logic signed [sph_pkg::SUM_W-1:0]    sx, sy, sz;
  logic                                sat_x, sat_y, sat_z;

  assign r_s     = $signed({1'b0, radius});
  assign neg_cos = -cos_lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
    end else if (en) begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1   <= r_s * sin_lat;
      pz1   <= r_s * neg_cos;
      clon1 <= cos_lon;
      slon1 <= sin_lon;

      t2    <= sph_pkg::TERM_W'((pt1 + HALF_P) >>> sph_pkg::TRIG_FRAC);
      zt2   <= sph_pkg::TERM_W'((pz1 + HALF_P) >>> sph_pkg::TRIG_FRAC);
      clon2 <= clon1;
      slon2 <= slon1;

      px3   <= t2 * clon2;
      py3   <= t2 * slon2;
      zt3   <= zt2;

      xt4   <= xt_n;
      yt4   <= yt_n;
      zt4   <= zt_n;
    end
  end

  // poles skip the trigonometry: only z moves, by the full radius
  always_comb begin
    xt_n = sph_pkg::TERM_W'((px3 + HALF_P2) >>> sph_pkg::TRIG_FRAC);
    yt_n = sph_pkg::TERM_W'((py3 + HALF_P2) >>> sph_pkg::TRIG_FRAC);
    zt_n = zt3;
    if (ctl3.pole_s || ctl3.pole_n) begin
      xt_n = '0;
      yt_n = '0;
      zt_n = ctl3.pole_s ? -sph_pkg::TERM_W'(r_s) : sph_pkg::TERM_W'(r_s);
    end
  end

  always_comb begin
    sx    = sph_pkg::SUM_W'(center_x) + sph_pkg::SUM_W'(xt4);
    sy    = sph_pkg::SUM_W'(center_y) + sph_pkg::SUM_W'(yt4);
    sz    = sph_pkg::SUM_W'(center_z) + sph_pkg::SUM_W'(zt4);
    sat_x = (sx > SUM_MAX) || (sx < SUM_MIN);
    sat_y = (sy > SUM_MAX) || (sy < SUM_MIN);
    sat_z = (sz > SUM_MAX) || (sz < SUM_MIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index_invalid <= ctl4.invalid;
      if (ctl4.invalid) begin
        coord_x   <= '0;
        coord_y   <= '0;
        coord_z   <= '0;
        saturated <= 1'b0;
      end else begin
        coord_x   <= sx > SUM_MAX ? SUM_MAX[sph_pkg::COORD_W-1:0] :
                     sx < SUM_MIN ? SUM_MIN[sph_pkg::COORD_W-1:0] : sx[sph_pkg::COORD_W-1:0];
        coord_y   <= sy > SUM_MAX ? SUM_MAX[sph_pkg::COORD_W-1:0] :
                     sy < SUM_MIN ? SUM_MIN[sph_pkg::COORD_W-1:0] : sy[sph_pkg::COORD_W-1:0];
        coord_z   <= sz > SUM_MAX ? SUM_MAX[sph_pkg::COORD_W-1:0] :
                     sz < SUM_MIN ? SUM_MIN[sph_pkg::COORD_W-1:0] : sz[sph_pkg::COORD_W-1:0];
        saturated <= sat_x || sat_y || sat_z;
      end
    end
  end

endmodule

[rtl/core/sphere_vertex_generator.sv]
// Accepted indices pass the index, phase, CORDIC and scale blocks to the output register.
// Throughput: one vertex per cycle; every stage advances together whenever the output
// register is empty or being taken, so a stall holds the whole pipeline in place.
// Depth is set by the 32-bit phase divider (9 registers) and the 30-rotation CORDIC (12).
// Reset (rst, synchronous): clears all valid bits and loads the default configuration.
`timescale 1ns / 1ps

module sphere_vertex_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sph_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [sph_pkg::CFG_W-1:0]        cfg_data,
  sph_in_if.sink                           vertex_in,
  sph_out_if.source                        vertex_out
);

  logic [sph_pkg::RES_W-1:0]          resolution;
  logic [sph_pkg::RAD_W-1:0]          sphere_radius;
  logic signed [sph_pkg::COORD_W-1:0] center_x;
  logic signed [sph_pkg::COORD_W-1:0] center_y;
  logic signed [sph_pkg::COORD_W-1:0] center_z;

  logic                               en;
  sph_pkg::ctl_t                      idx_ctl;
  logic [sph_pkg::RES_W-1:0]          n_lat;
  logic [sph_pkg::RES_W-1:0]          n_lon;
  sph_pkg::ctl_t                      ph_ctl;
  logic [sph_pkg::PHASE_W-1:0]        phase_lat;
  logic [sph_pkg::PHASE_W-1:0]        phase_lon;
  sph_pkg::ctl_t                      trig_ctl;
  logic signed [sph_pkg::UNIT_W-1:0]  cos_lat, sin_lat, cos_lon, sin_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution    <= sph_pkg::RES_RESET;
      sphere_radius <= sph_pkg::RADIUS_RESET;
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sph_pkg::REG_RESOLUTION: resolution    <= cfg_data[sph_pkg::RES_W-1:0];
        sph_pkg::REG_RADIUS:     sphere_radius <= cfg_data[sph_pkg::RAD_W-1:0];
        sph_pkg::REG_CENTER_X:   center_x      <= cfg_data[sph_pkg::COORD_W-1:0];
        sph_pkg::REG_CENTER_Y:   center_y      <= cfg_data[sph_pkg::COORD_W-1:0];
        sph_pkg::REG_CENTER_Z:   center_z      <= cfg_data[sph_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // advance every stage unless a finished item is held at the output
  assign en              = !vertex_out.valid || vertex_out.ready;
  assign vertex_in.ready = en;

  sph_index u_index (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .valid        (vertex_in.valid),
    .vertex_index (vertex_in.vertex_index),
    .resolution   (resolution),
    .ctl          (idx_ctl),
    .n_lat        (n_lat),
    .n_lon        (n_lon)
  );

  sph_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .ctl_in     (idx_ctl),
    .n_lat      (n_lat),
    .n_lon      (n_lon),
    .resolution (resolution),
    .ctl        (ph_ctl),
    .phase_lat  (phase_lat),
    .phase_lon  (phase_lon)
  );

  sph_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (ph_ctl),
    .phase_lat (phase_lat),
    .phase_lon (phase_lon),
    .ctl       (trig_ctl),
    .cos_lat   (cos_lat),
    .sin_lat   (sin_lat),
    .cos_lon   (cos_lon),
    .sin_lon   (sin_lon)
  );

  sph_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .ctl_in        (trig_ctl),
    .cos_lat       (cos_lat),
    .sin_lat       (sin_lat),
    .cos_lon       (cos_lon),
    .sin_lon       (sin_lon),
    .radius        (sphere_radius),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .out_valid     (vertex_out.valid),
    .coord_x       (vertex_out.coord_x),
    .coord_y       (vertex_out.coord_y),
    .coord_z       (vertex_out.coord_z),
    .index_invalid (vertex_out.index_invalid),
    .saturated     (vertex_out.saturated)
  );

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    vertex_out.valid && vertex_out.index_invalid
      |-> vertex_out.coord_x == '0 && vertex_out.coord_y == '0 &&
          vertex_out.coord_z == '0 && !vertex_out.saturated)
    else $error("invalid index with nonzero result");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    vertex_out.valid && vertex_out.saturated
      |-> vertex_out.coord_x == sph_pkg::COORD_MAX || vertex_out.coord_x == sph_pkg::COORD_MIN ||
          vertex_out.coord_y == sph_pkg::COORD_MAX || vertex_out.coord_y == sph_pkg::COORD_MIN ||
          vertex_out.coord_z == sph_pkg::COORD_MAX || vertex_out.coord_z == sph_pkg::COORD_MIN)
    else $error("saturated flag without a clamped coordinate");
`endif

endmodule
